@@ sv/sblc_pkg.sv @@
`timescale 1ns / 1ps

package sblc_pkg;

   // Field widths fixed by the interface.
   localparam int KEY_W      = 16;
   localparam int BYTES_W    = 24;
   localparam int STAMP_W    = 64;
   localparam int SLOT_OUT_W = 4;
   localparam int KIND_W     = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   // Defaults handed to the top level.
   localparam int ENTRIES_DEFAULT = 16;
   localparam logic [BYTES_W-1:0] BUDGET_RESET = 24'd4194304;

   // Request selector carried in req_tuser.
   localparam logic OP_ACCESS = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // Result kinds carried in rsp_tuser.
   typedef enum logic [KIND_W-1:0] {
      KIND_HIT     = 2'd0,
      KIND_INSERT  = 2'd1,
      KIND_EVICT   = 2'd2,
      KIND_CLEARED = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_HIT,
      ST_EVICT,
      ST_EVICT_FULL,
      ST_INSERT,
      ST_INSERT_OLD,
      ST_CLEAR
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic scan_start;
      logic hit;
      logic evict;
      logic insert;
      logic ins_old;
      logic clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
      logic hit_found;
      logic over;
      logic any_valid;
      logic any_free;
      logic out_free;
   } status_type;

endpackage

@@ sv/sblc_ctrl.sv @@
`timescale 1ns / 1ps

module sblc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tuser,
   output logic                req_tready,
   input  sblc_pkg::status_type status,
   output sblc_pkg::cmd_type    cmd
);

   sblc_pkg::state_type state_ff;
   sblc_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sblc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sblc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == sblc_pkg::OP_CLEAR) begin
                  state_in = sblc_pkg::ST_CLEAR;
               end else begin
                  state_in = sblc_pkg::ST_SCAN;
               end
            end
         end
         sblc_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               if (status.hit_found) begin
                  state_in = sblc_pkg::ST_HIT;
               end else if (status.over && status.any_valid) begin
                  state_in = sblc_pkg::ST_EVICT;
               end else if (!status.any_free) begin
                  state_in = sblc_pkg::ST_EVICT_FULL;
               end else begin
                  state_in = sblc_pkg::ST_INSERT;
               end
            end
         end
         sblc_pkg::ST_EVICT: begin
            if (status.out_free) begin
               state_in = sblc_pkg::ST_SCAN;
            end
         end
         sblc_pkg::ST_EVICT_FULL: begin
            if (status.out_free) begin
               state_in = sblc_pkg::ST_INSERT_OLD;
            end
         end
         sblc_pkg::ST_HIT, sblc_pkg::ST_INSERT, sblc_pkg::ST_INSERT_OLD,
         sblc_pkg::ST_CLEAR: begin
            if (status.out_free) begin
               state_in = sblc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sblc_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         sblc_pkg::ST_IDLE: begin
            req_tready     = 1'b1;
            cmd.take       = req_tvalid;
            cmd.scan_start = req_tvalid && (req_tuser == sblc_pkg::OP_ACCESS);
         end
         sblc_pkg::ST_HIT: begin
            cmd.hit = status.out_free;
         end
         sblc_pkg::ST_EVICT: begin
            cmd.evict      = status.out_free;
            cmd.scan_start = status.out_free;
         end
         sblc_pkg::ST_EVICT_FULL: begin
            cmd.evict = status.out_free;
         end
         sblc_pkg::ST_INSERT: begin
            cmd.insert = status.out_free;
         end
         sblc_pkg::ST_INSERT_OLD: begin
            cmd.insert  = status.out_free;
            cmd.ins_old = status.out_free;
         end
         sblc_pkg::ST_CLEAR: begin
            cmd.clear = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ sv/sblc_datapath.sv @@
`timescale 1ns / 1ps

module sblc_datapath #(
   parameter int ENTRIES = sblc_pkg::ENTRIES_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [sblc_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 csr_we,
   input  logic [sblc_pkg::BYTES_W-1:0]         csr_wdata,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [sblc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [sblc_pkg::KIND_W-1:0]          rsp_tuser,
   output logic                                 rsp_tlast,
   input  sblc_pkg::cmd_type                    cmd,
   output sblc_pkg::status_type                 status
);

   localparam int SW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] CNT_END = CW'(ENTRIES);

   localparam int KW = sblc_pkg::KEY_W;
   localparam int BW = sblc_pkg::BYTES_W;
   localparam int TW = sblc_pkg::STAMP_W;

   // Tag table memories.
   logic [KW-1:0] key_mem   [ENTRIES];
   logic [BW-1:0] size_mem  [ENTRIES];
   logic [TW-1:0] stamp_mem [ENTRIES];

   logic [ENTRIES-1:0] valid_ff;
   logic [BW-1:0]      used_ff;
   logic [TW-1:0]      clock_ff;
   logic [BW-1:0]      budget_ff;

   logic [KW-1:0]      req_key_ff;
   logic [BW-1:0]      req_size_ff;

   logic [CW-1:0]      cnt_ff;
   logic               rd_ok_ff;
   logic [SW-1:0]      rd_idx_ff;
   logic [KW-1:0]      rd_key_ff;
   logic [BW-1:0]      rd_size_ff;
   logic [TW-1:0]      rd_stamp_ff;

   logic               hit_found_ff;
   logic [SW-1:0]      hit_slot_ff;
   logic               best_found_ff;
   logic [SW-1:0]      best_slot_ff;
   logic [KW-1:0]      best_key_ff;
   logic [BW-1:0]      best_size_ff;
   logic [TW-1:0]      best_stamp_ff;
   logic               free_found_ff;
   logic [SW-1:0]      free_slot_ff;

   logic                  out_valid_ff;
   sblc_pkg::kind_type    out_kind_ff;
   logic [SW-1:0]         out_slot_ff;
   logic [KW-1:0]         out_key_ff;
   logic [BW-1:0]         out_bytes_ff;
   logic                  out_last_ff;

   logic          issue;
   logic          rd_valid;
   logic [SW-1:0] ins_slot;
   logic [TW-1:0] next_stamp;
   logic [BW-1:0] used_after_evict;
   logic [BW-1:0] used_after_insert;
   logic          load_out;
   logic          out_free;
   logic [SW+3:0] slot_wide;

   assign issue             = (cnt_ff != CNT_END);
   assign rd_valid          = valid_ff[rd_idx_ff];
   assign ins_slot          = cmd.ins_old ? best_slot_ff : free_slot_ff;
   assign next_stamp        = clock_ff + TW'(1);
   assign used_after_evict  = used_ff - best_size_ff;
   assign used_after_insert = used_ff + req_size_ff;
   assign load_out          = cmd.hit | cmd.evict | cmd.insert | cmd.clear;
   assign out_free          = !out_valid_ff || rsp_tready;

   // Status to the controller.
   always_comb begin
      status.scan_done = !issue && !rd_ok_ff;
      status.hit_found = hit_found_ff;
      status.over      = ({1'b0, used_ff} + {1'b0, req_size_ff}) > {1'b0, budget_ff};
      status.any_valid = best_found_ff;
      status.any_free  = free_found_ff;
      status.out_free  = out_free;
   end

   // Memory write and registered scan read.
   always_ff @(posedge clock) begin
      if (cmd.hit) begin
         stamp_mem[hit_slot_ff] <= next_stamp;
      end else if (cmd.insert) begin
         key_mem[ins_slot]   <= req_key_ff;
         size_mem[ins_slot]  <= req_size_ff;
         stamp_mem[ins_slot] <= next_stamp;
      end
      rd_key_ff   <= key_mem[cnt_ff[SW-1:0]];
      rd_size_ff  <= size_mem[cnt_ff[SW-1:0]];
      rd_stamp_ff <= stamp_mem[cnt_ff[SW-1:0]];
      rd_idx_ff   <= cnt_ff[SW-1:0];
   end

   // Table state, budget and use clock.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         used_ff   <= '0;
         clock_ff  <= '0;
         budget_ff <= sblc_pkg::BUDGET_RESET;
      end else begin
         if (csr_we) begin
            budget_ff <= csr_wdata;
         end
         if (cmd.clear) begin
            valid_ff <= '0;
            used_ff  <= '0;
         end else if (cmd.evict) begin
            valid_ff[best_slot_ff] <= 1'b0;
            used_ff                <= used_after_evict;
         end else if (cmd.insert) begin
            valid_ff[ins_slot] <= 1'b1;
            used_ff            <= used_after_insert;
         end
         if (cmd.hit || cmd.insert) begin
            clock_ff <= next_stamp;
         end
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         req_key_ff  <= req_tdata[KW-1:0];
         req_size_ff <= req_tdata[KW+BW-1:KW];
      end
   end

   // Scan counter and read pipeline flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= CNT_END;
         rd_ok_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         cnt_ff   <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         rd_ok_ff <= issue;
         if (issue) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
      end
   end

   // Scan results: first match, oldest valid entry, first free slot.
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_start) begin
         hit_found_ff  <= 1'b0;
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (rd_ok_ff) begin
         if (rd_valid && (rd_key_ff == req_key_ff) && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
            hit_slot_ff  <= rd_idx_ff;
         end
         if (rd_valid && (!best_found_ff || (rd_stamp_ff < best_stamp_ff))) begin
            best_found_ff <= 1'b1;
            best_slot_ff  <= rd_idx_ff;
            best_key_ff   <= rd_key_ff;
            best_size_ff  <= rd_size_ff;
            best_stamp_ff <= rd_stamp_ff;
         end
         if (!rd_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_slot_ff  <= rd_idx_ff;
         end
      end
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (cmd.hit) begin
         out_kind_ff  <= sblc_pkg::KIND_HIT;
         out_slot_ff  <= hit_slot_ff;
         out_key_ff   <= req_key_ff;
         out_bytes_ff <= used_ff;
         out_last_ff  <= 1'b1;
      end else if (cmd.evict) begin
         out_kind_ff  <= sblc_pkg::KIND_EVICT;
         out_slot_ff  <= best_slot_ff;
         out_key_ff   <= best_key_ff;
         out_bytes_ff <= used_after_evict;
         out_last_ff  <= 1'b0;
      end else if (cmd.insert) begin
         out_kind_ff  <= sblc_pkg::KIND_INSERT;
         out_slot_ff  <= ins_slot;
         out_key_ff   <= req_key_ff;
         out_bytes_ff <= used_after_insert;
         out_last_ff  <= 1'b1;
      end else if (cmd.clear) begin
         out_kind_ff  <= sblc_pkg::KIND_CLEARED;
         out_slot_ff  <= '0;
         out_key_ff   <= '0;
         out_bytes_ff <= '0;
         out_last_ff  <= 1'b1;
      end
   end

   assign slot_wide  = {4'b0000, out_slot_ff};
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'b0000, out_bytes_ff, out_key_ff, slot_wide[3:0]};

   // An eviction always has a valid oldest entry behind it.
   a_evict_has_victim: assert property (@(posedge clock) disable iff (reset)
      cmd.evict |-> best_found_ff)
      else $error("eviction without a valid victim");

   // An insert lands only on a slot that is free at that moment.
   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |-> !valid_ff[ins_slot])
      else $error("insert over a valid entry");

   // A new result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!out_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

endmodule

@@ sv/size_budget_lru_cache_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// req_      in         req_tvalid / req_tready   tuser: op; tdata: key, entry_bytes
// rsp_      out        rsp_tvalid / rsp_tready   tuser: kind; tdata: slot, key, bytes;
//                                                tlast: final result of the beat
// csr_      in         csr_we                    csr_wdata: byte budget
//
// One beat at a time. A hit or miss check scans the table through the single
// read port of the tag memories; every budget eviction costs one more scan,
// and a full table evicts its oldest entry before the insert. A clear needs no
// scan. Reset is synchronous and empties the table.
// A stalled result holds in the output register; the next request is taken
// meanwhile, and its results wait until the register frees.

module size_budget_lru_cache_top #(
   parameter int ENTRIES = sblc_pkg::ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sblc_pkg::REQ_DATA_W-1:0]   req_tdata,   // key, entry_bytes
   input  logic                              req_tuser,   // op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sblc_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // slot, result_key, bytes_in_use
   output logic [sblc_pkg::KIND_W-1:0]       rsp_tuser,   // kind
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [sblc_pkg::BYTES_W-1:0]      csr_wdata
);

   sblc_pkg::cmd_type    cmd;
   sblc_pkg::status_type status;

   sblc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sblc_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
